@@ design/tal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tal_pkg;

    localparam int UID_W   = 56;
    localparam int LEN_W   = 3;
    localparam int LABEL_W = 7;
    localparam int EVENT_W = 3;

    localparam logic [EVENT_W-1:0] EV_MODE_ON  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_MODE_OFF = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ENROLLED = 3'd2;
    localparam logic [EVENT_W-1:0] EV_REMOVED  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FULL     = 3'd4;
    localparam logic [EVENT_W-1:0] EV_GRANTED  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_DENIED   = 3'd6;

    localparam logic CFG_MASTER_UID = 1'b0;
    localparam logic CFG_MASTER_LEN = 1'b1;

    localparam logic [UID_W-1:0] MASTER_UID_RST = 56'h0D29_FA00;
    localparam logic [LEN_W-1:0] MASTER_LEN_RST = 3'd4;

    typedef struct packed {
        logic [UID_W-1:0]   uid;
        logic [LEN_W-1:0]   len;
        logic [LABEL_W-1:0] label;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } t_state;

    function automatic logic [UID_W-1:0] keep_bytes(input logic [UID_W-1:0] v,
                                                    input logic [LEN_W-1:0] len);
        logic [UID_W-1:0] m;
        case (len)
            3'd0:    m = 56'h0;
            3'd1:    m = 56'h0000_0000_0000_FF;
            3'd2:    m = 56'h0000_0000_00FF_FF;
            3'd3:    m = 56'h0000_0000_FFFF_FF;
            3'd4:    m = 56'h0000_00FF_FFFF_FF;
            3'd5:    m = 56'h0000_FFFF_FFFF_FF;
            3'd6:    m = 56'h00FF_FFFF_FFFF_FF;
            default: m = 56'hFF_FFFF_FFFF_FFFF;
        endcase
        return v & m;
    endfunction

endpackage
`default_nettype wire

@@ design/tal_entry_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tal_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire tal_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output tal_pkg::t_entry      o_rdata
);
    import tal_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/tag_access_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake               | Payload
// input    | in        | i_in_valid / o_in_ready | i_uid, i_uid_length
// result   | out       | o_out_valid/i_out_ready | o_event_res, o_user_label,
//          |           |                         | o_enroll_mode, o_entry_count
// config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A master card toggles the mode without a pass over the table; any other
// card takes a search pass up to the first match, and on removal a shift
// pass over the later entries that moves them down one place.
// Both passes stream through the single read port of the entry memory.
// Reset clears mode, count and handshake state; the table needs no clearing.
// A held result does not block the next transfer in; it stalls only finish.
module tag_access_list #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [tal_pkg::UID_W-1:0] i_uid,
    input  wire logic [tal_pkg::LEN_W-1:0] i_uid_length,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [tal_pkg::EVENT_W-1:0]   o_event_res,
    output logic [tal_pkg::LABEL_W-1:0]   o_user_label,
    output logic                          o_enroll_mode,
    output logic [tal_pkg::LABEL_W-1:0]   o_entry_count,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic                     i_cfg_index,
    input  wire logic [tal_pkg::UID_W-1:0] i_cfg_data
);
    import tal_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state             r_state, n_state;
    logic [UID_W-1:0]   r_uid;
    logic [LEN_W-1:0]   r_len;
    logic [UID_W-1:0]   r_master_uid;
    logic [LEN_W-1:0]   r_master_len;
    logic [CW-1:0]      r_total, n_total;
    logic               r_mode, n_mode;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [CW-1:0]      r_pend_addr, n_pend_addr;
    logic [EVENT_W-1:0] r_event, n_event;
    logic [LABEL_W-1:0] r_label, n_label;

    logic               r_out_vld;
    logic [EVENT_W-1:0] r_out_event;
    logic [LABEL_W-1:0] r_out_label;
    logic               r_out_mode;
    logic [LABEL_W-1:0] r_out_count;

    logic    ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry  ram_wdata;
    t_entry  ram_rdata;

    logic in_xfer, out_load, is_master, hit, scan_end, more, full;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_load  = (r_state == ST_DONE) && (!r_out_vld || i_out_ready);
    assign is_master = (r_len == r_master_len)
                       && (r_uid == keep_bytes(r_master_uid, r_master_len));
    assign hit       = r_pend && (ram_rdata.len == r_len) && (ram_rdata.uid == r_uid);
    assign more      = r_idx < r_total;
    assign scan_end  = !r_pend && !more;
    assign full      = r_total == CW'(MAX_ENTRIES);

    tal_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = is_master ? ST_DONE : ST_SEARCH;
            end
            ST_SEARCH: begin
                if (hit) n_state = r_mode ? ST_SHIFT : ST_DONE;
                else if (scan_end) n_state = ST_DONE;
            end
            ST_SHIFT: begin
                if (scan_end) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_total     = r_total;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_addr = r_idx;
        n_event     = r_event;
        n_label     = r_label;
        ram_we      = 1'b0;
        ram_waddr   = r_total[AW-1:0];
        ram_wdata   = '{uid: r_uid, len: r_len, label: LABEL_W'(r_total) + 1'b1};
        case (r_state)
            ST_CHECK: begin
                n_idx   = '0;
                n_label = '0;
                if (is_master) begin
                    n_mode  = !r_mode;
                    n_event = r_mode ? EV_MODE_OFF : EV_MODE_ON;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    if (r_mode) begin
                        n_event = EV_REMOVED;
                        n_idx   = r_pend_addr + 1'b1;
                    end else begin
                        n_event = EV_GRANTED;
                        n_label = ram_rdata.label;
                    end
                end else if (scan_end) begin
                    if (!r_mode) begin
                        n_event = EV_DENIED;
                    end else if (full) begin
                        n_event = EV_FULL;
                    end else begin
                        n_event = EV_ENROLLED;
                        n_label = LABEL_W'(r_total) + 1'b1;
                        n_total = r_total + 1'b1;
                        ram_we  = 1'b1;
                    end
                end else begin
                    n_pend = more;
                    if (more) n_idx = r_idx + 1'b1;
                end
            end
            ST_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_pend_addr - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (scan_end) begin
                    n_total = r_total - 1'b1;
                end else begin
                    n_pend = more;
                    if (more) n_idx = r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_vld;
    assign o_event_res   = r_out_event;
    assign o_user_label  = r_out_label;
    assign o_enroll_mode = r_out_mode;
    assign o_entry_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_total      <= '0;
            r_mode       <= 1'b0;
            r_pend       <= 1'b0;
            r_out_vld    <= 1'b0;
            r_master_uid <= MASTER_UID_RST;
            r_master_len <= MASTER_LEN_RST;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MASTER_UID: r_master_uid <= i_cfg_data;
                    CFG_MASTER_LEN: r_master_len <= i_cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_event     <= n_event;
        r_label     <= n_label;
        if (in_xfer) begin
            r_uid <= keep_bytes(i_uid, i_uid_length);
            r_len <= i_uid_length;
        end
        if (out_load) begin
            r_out_event <= r_event;
            r_out_label <= r_label;
            r_out_mode  <= r_mode;
            r_out_count <= LABEL_W'(r_total);
        end
    end

endmodule
`default_nettype wire

@@ sim/tag_access_list_tb.sv @@
`timescale 1ns / 1ps
module tag_access_list_tb;
    import tal_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int POOL_SIZE   = 72;

    typedef struct packed {
        logic [EVENT_W-1:0] code;
        logic [LABEL_W-1:0] label;
        logic               mode;
        logic [LABEL_W-1:0] count;
    } t_card_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [UID_W-1:0]   i_uid;
    logic [LEN_W-1:0]   i_uid_length;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [EVENT_W-1:0] o_event_res;
    logic [LABEL_W-1:0] o_user_label;
    logic               o_enroll_mode;
    logic [LABEL_W-1:0] o_entry_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [UID_W-1:0]   i_cfg_data;

    logic [UID_W-1:0]   acl_uid   [TABLE_DEPTH];
    logic [LEN_W-1:0]   acl_len   [TABLE_DEPTH];
    logic [LABEL_W-1:0] acl_label [TABLE_DEPTH];
    int                 acl_count;
    logic               enroll_on;
    logic [UID_W-1:0]   master_id;
    logic [LEN_W-1:0]   master_len;

    logic [UID_W-1:0]   pool_uid [POOL_SIZE];
    logic [LEN_W-1:0]   pool_len [POOL_SIZE];

    t_card_result       expected_results[$];
    int                 errors;
    bit                 sender_gaps_on;
    bit                 receiver_stalls_on;
    int                 hold_cycles;

    tag_access_list #(.MAX_ENTRIES(TABLE_DEPTH)) dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [UID_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [63:0] m;
        m = (64'd1 << (8 * n)) - 64'd1;
        return m[UID_W-1:0];
    endfunction

    function automatic logic [UID_W-1:0] rand_uid();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[UID_W-1:0];
    endfunction

    // fill the bytes above the length with junk
    function automatic logic [UID_W-1:0] with_junk(input logic [UID_W-1:0] v,
                                                   input logic [LEN_W-1:0] n);
        return (v & byte_mask(n)) | (rand_uid() & ~byte_mask(n));
    endfunction

    function automatic t_card_result grade_card(input logic [UID_W-1:0] uid,
                                                input logic [LEN_W-1:0] n);
        logic [UID_W-1:0] v;
        int               pos;
        int               i;
        t_card_result     r;
        v = uid & byte_mask(n);
        r = '0;
        if (n == master_len && v == (master_id & byte_mask(master_len))) begin
            enroll_on = ~enroll_on;
            r.code = enroll_on ? EV_MODE_ON : EV_MODE_OFF;
        end else begin
            pos = acl_count;
            for (i = 0; i < acl_count; i++) begin
                if (pos == acl_count && acl_len[i] == n && acl_uid[i] == v) begin
                    pos = i;
                end
            end
            if (enroll_on) begin
                if (pos < acl_count) begin
                    for (i = pos; i < acl_count - 1; i++) begin
                        acl_uid[i]   = acl_uid[i + 1];
                        acl_len[i]   = acl_len[i + 1];
                        acl_label[i] = acl_label[i + 1];
                    end
                    acl_count--;
                    r.code = EV_REMOVED;
                end else if (acl_count < TABLE_DEPTH) begin
                    acl_uid[acl_count]   = v;
                    acl_len[acl_count]   = n;
                    acl_label[acl_count] = LABEL_W'(acl_count + 1);
                    r.label = LABEL_W'(acl_count + 1);
                    acl_count++;
                    r.code = EV_ENROLLED;
                end else begin
                    r.code = EV_FULL;
                end
            end else if (pos < acl_count) begin
                r.label = acl_label[pos];
                r.code = EV_GRANTED;
            end else begin
                r.code = EV_DENIED;
            end
        end
        r.mode = enroll_on;
        r.count = LABEL_W'(acl_count);
        return r;
    endfunction

    task automatic send_card(input logic [UID_W-1:0] uid, input logic [LEN_W-1:0] n);
        @(negedge i_clk);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_uid = uid;
        i_uid_length = n;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(grade_card(uid, n));
    endtask

    task automatic present_master();
        send_card(with_junk(master_id, master_len), master_len);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [UID_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MASTER_UID) begin
            master_id = data;
        end else begin
            master_len = data[LEN_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_master(input logic [UID_W-1:0] uid, input logic [LEN_W-1:0] n);
        logic [UID_W-1:0] data;
        data = rand_uid();
        data[LEN_W-1:0] = n;
        settle();
        write_reg(CFG_MASTER_UID, uid);
        write_reg(CFG_MASTER_LEN, data);
    endtask

    task automatic test_directed();
        present_master();
        send_card({UID_W{1'b1}}, 3'd7);
        send_card(56'h0, 3'd1);
        send_card(rand_uid(), 3'd0);
        send_card(56'h0, 3'd2);
        send_card(56'h0D29FA00, 3'd5);
        present_master();
        send_card({UID_W{1'b1}}, 3'd7);
        send_card(56'hAB_CDEF_0000_0000, 3'd1);
        send_card(rand_uid(), 3'd0);
        send_card(with_junk(56'h55, 3'd3), 3'd3);
        present_master();
        send_card({UID_W{1'b1}}, 3'd7);
        send_card(56'h55, 3'd3);
        present_master();
        send_card(56'h55, 3'd3);
        send_card(with_junk(56'h0D29FA00, 3'd5), 3'd5);
        send_card({UID_W{1'b1}}, 3'd7);
        present_master();
        send_card(56'h0, 3'd0);
        send_card(56'h55, 3'd3);
        present_master();
        settle();
    endtask

    task automatic test_config();
        set_master(rand_uid(), 3'd0);
        present_master();
        send_card(rand_uid(), 3'd7);
        present_master();
        set_master({UID_W{1'b1}}, 3'd7);
        present_master();
        send_card({UID_W{1'b1}}, 3'd6);
        present_master();
        set_master(56'h0, 3'd1);
        present_master();
        send_card(56'h0, 3'd2);
        present_master();
        send_card(56'h0, 3'd2);
        settle();
    endtask

    task automatic test_full();
        int i;
        if (!enroll_on) begin
            present_master();
        end
        i = 0;
        while (acl_count < TABLE_DEPTH) begin
            send_card({16'hC0DE, 8'h00, 32'(i)}, 3'd7);
            i++;
        end
        send_card({16'hC0DE, 8'h00, 32'(i)}, 3'd7);
        send_card(rand_uid(), 3'd2);
        present_master();
        send_card(acl_uid[TABLE_DEPTH - 1], acl_len[TABLE_DEPTH - 1]);
        send_card(acl_uid[0], acl_len[0]);
        present_master();
        send_card(acl_uid[0], acl_len[0]);
        send_card(acl_uid[30], acl_len[30]);
        send_card({16'hC0DE, 8'h00, 32'(i)}, 3'd7);
        present_master();
        settle();
    endtask

    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        hold_cycles = 400;
        repeat (16) send_card(rand_uid(), 3'($urandom_range(1, 7)));
        settle();
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        int               k;
        int               r;
        int               idx;
        int               span;
        int               round;
        logic [LEN_W-1:0] n;
        for (k = 0; k < POOL_SIZE; k++) begin
            pool_uid[k] = rand_uid();
            pool_len[k] = 3'($urandom_range(1, 7));
        end
        pool_len[0] = 3'd0;
        for (round = 0; round < 14; round++) begin
            if (round >= 12) begin
                sender_gaps_on = 1'b0;
                receiver_stalls_on = 1'b0;
            end else begin
                sender_gaps_on = $urandom_range(0, 3) != 0;
                receiver_stalls_on = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 1) == 1) begin
                r = $urandom_range(0, 9);
                idx = $urandom_range(0, POOL_SIZE - 1);
                if (r == 0) begin
                    set_master(pool_uid[idx], pool_len[idx]);
                end else if (r == 1) begin
                    set_master(rand_uid(), 3'd0);
                end else if (r == 2) begin
                    set_master(MASTER_UID_RST, MASTER_LEN_RST);
                end else begin
                    set_master(rand_uid(), 3'($urandom_range(1, 7)));
                end
            end
            r = $urandom_range(0, 2);
            span = (r == 0) ? 8 : ((r == 1) ? 40 : POOL_SIZE);
            for (k = 0; k < 100; k++) begin
                r = $urandom_range(0, 99);
                idx = $urandom_range(0, span - 1);
                if (r < 10) begin
                    present_master();
                end else if (r < 80) begin
                    send_card(with_junk(pool_uid[idx], pool_len[idx]), pool_len[idx]);
                end else if (r < 90) begin
                    n = pool_len[idx] + 3'($urandom_range(1, 7));
                    send_card(pool_uid[idx], n);
                end else begin
                    send_card(rand_uid(), 3'($urandom_range(0, 7)));
                end
            end
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready = 1'b0;
                while (hold_cycles > 0) begin
                    @(negedge i_clk);
                    hold_cycles--;
                end
                i_out_ready = 1'b1;
            end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_card_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer: expected none, actual event_res %0d",
                         $time, o_event_res);
            end else begin
                want = expected_results.pop_front();
                if (o_event_res !== want.code) begin
                    errors++;
                    $display("%0t event_res: expected %0d, actual %0d",
                             $time, want.code, o_event_res);
                end
                if (o_user_label !== want.label) begin
                    errors++;
                    $display("%0t user_label: expected %0d, actual %0d",
                             $time, want.label, o_user_label);
                end
                if (o_enroll_mode !== want.mode) begin
                    errors++;
                    $display("%0t enroll_mode: expected %0d, actual %0d",
                             $time, want.mode, o_enroll_mode);
                end
                if (o_entry_count !== want.count) begin
                    errors++;
                    $display("%0t entry_count: expected %0d, actual %0d",
                             $time, want.count, o_entry_count);
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("tag_access_list: mismatch");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_uid = '0;
        i_uid_length = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MASTER_UID;
        i_cfg_data = '0;
        errors = 0;
        hold_cycles = 0;
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
        acl_count = 0;
        enroll_on = 1'b0;
        master_id = MASTER_UID_RST;
        master_len = MASTER_LEN_RST;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config();
        test_full();
        test_backpressure();
        test_random();
        settle();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tag_access_list: match");
        end else begin
            $display("tag_access_list: mismatch");
        end
        $finish;
    end

endmodule
